// ----- rtl/sacl_pkg.sv -----
// Shared types and constants for the set-associative cache tag lookup unit.
// Used by sacl_way_select and set_assoc_cache_tag_lookup_unit; no dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int BYTE_BITS      = 2;
   localparam int MAX_SET_BITS   = 6;
   localparam int MAX_WAYS       = 8;
   localparam int MAX_WORD_BITS  = 8;
   localparam int TAG_BITS       = 30;
   localparam int NUM_SETS       = 1 << MAX_SET_BITS;
   localparam int WAY_IDX_BITS   = $clog2(MAX_WAYS);
   localparam int WAY_CNT_BITS   = $clog2(MAX_WAYS + 1);
   localparam int SBITS_W        = 3;
   localparam int WBITS_W        = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;
   localparam int COUNT_BITS     = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SET_INDEX_BITS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAYS_IN_USE      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORD_OFFSET_BITS = 2'd2;

   typedef logic [TAG_BITS-1:0] tag_type;

   // One memory row holds a whole set: replacement pointer, valid bits and tags.
   typedef struct packed {
      logic [WAY_IDX_BITS-1:0]   victim;
      logic [MAX_WAYS-1:0]       valid;
      tag_type [MAX_WAYS-1:0]    tag;
   } row_type;

   typedef struct packed {
      logic    hit;
      row_type row;
   } lookup_type;

endpackage

// ----- rtl/sacl_way_select.sv -----
// Way search and replacement decision for one set row.
// Depends on sacl_pkg for the row and result types.
`timescale 1ns / 1ps

module sacl_way_select (
   input  sacl_pkg::row_type                     row_in,
   input  sacl_pkg::tag_type                     tag_in,
   input  logic [sacl_pkg::WAY_CNT_BITS-1:0]     ways_in,
   output sacl_pkg::lookup_type                  result_out
);
   import sacl_pkg::*;

   always_comb begin
      logic                    decided;
      logic [WAY_IDX_BITS-1:0] victim;
      logic [WAY_CNT_BITS-1:0] victim_next;

      decided           = 1'b0;
      result_out.hit    = 1'b0;
      result_out.row    = row_in;
      victim            = row_in.victim;
      victim_next       = '0;

      // The first way in order that is empty or matches decides.
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!decided && (WAY_CNT_BITS'(w) < ways_in)) begin
            if (!row_in.valid[w]) begin
               result_out.row.valid[w] = 1'b1;
               result_out.row.tag[w]   = tag_in;
               decided                 = 1'b1;
            end else if (row_in.tag[w] == tag_in) begin
               result_out.hit = 1'b1;
               decided        = 1'b1;
            end
         end
      end

      // Full set: replace under the round-robin pointer. A pointer left over
      // from a larger way count restarts at way 0.
      if (!decided) begin
         if ({1'b0, row_in.victim} >= ways_in) begin
            victim = '0;
         end
         result_out.row.valid[victim] = 1'b1;
         result_out.row.tag[victim]   = tag_in;
         victim_next                  = WAY_CNT_BITS'(victim) + WAY_CNT_BITS'(1);
         result_out.row.victim        = (victim_next == ways_in) ? '0
                                        : victim_next[WAY_IDX_BITS-1:0];
      end
   end

endmodule

// ----- rtl/set_assoc_cache_tag_lookup_unit.sv -----
// Top level of the set-associative cache tag lookup unit with FIFO replacement.
// Depends on sacl_pkg and sacl_way_select.
`timescale 1ns / 1ps

// Each request word carries a 32-bit byte address and produces exactly one
// response word with the hit flag and the saturating hit and miss totals.
// The set's row is read from the tag memory into a register when the request
// is accepted; then the ways are searched and the updated row is written back
// once the output register is free. A new request is not taken until that
// write-back is done, as the single-port row memory requires. A finished
// response sits in an output register, and the next request is accepted while
// it waits. Valid bits and replacement pointers of unwritten sets read as zero
// through one row-valid flop per set, so no clearing pass follows reset.
// Configuration is to be written only while the unit is idle; the unit does not enforce this.
module set_assoc_cache_tag_lookup_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sacl_pkg::ADDR_BITS-1:0]       req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [sacl_pkg::COUNT_BITS-1:0]      rsp_hit_total,
   output logic [sacl_pkg::COUNT_BITS-1:0]      rsp_miss_total,
   input  logic                                 csr_write_enable,
   input  logic [sacl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sacl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [SBITS_W-1:0]        set_index_bits_ff;
   logic [WAY_CNT_BITS-1:0]   ways_in_use_ff;
   logic [WBITS_W-1:0]        word_offset_bits_ff;
   logic [ADDR_BITS-1:0]      addr_ff;
   logic [MAX_SET_BITS-1:0]   set_ff, set_in;
   logic [NUM_SETS-1:0]       row_valid_ff;
   row_type                   rd_row_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff;
   logic [COUNT_BITS-1:0]     hit_total_ff, miss_total_ff;

   row_type                   tag_mem [NUM_SETS];

   logic                      accept;
   logic                      fire;
   logic [SBITS_W-1:0]        sbits;
   logic [WAY_CNT_BITS-1:0]   ways;
   logic [WBITS_W-1:0]        wbits;
   logic [WBITS_W-1:0]        offset;
   logic [ADDR_BITS-1:0]      req_block;
   logic [ADDR_BITS-1:0]      cur_block;
   logic [MAX_SET_BITS-1:0]   set_mask;
   tag_type                   cur_tag;
   row_type                   cur_row;
   lookup_type                lookup;

   // Clamped configuration.
   always_comb begin
      sbits    = (set_index_bits_ff > SBITS_W'(MAX_SET_BITS)) ? SBITS_W'(MAX_SET_BITS)
                 : set_index_bits_ff;
      ways     = (ways_in_use_ff == '0) ? WAY_CNT_BITS'(1)
                 : (ways_in_use_ff > WAY_CNT_BITS'(MAX_WAYS)) ? WAY_CNT_BITS'(MAX_WAYS)
                 : ways_in_use_ff;
      wbits    = (word_offset_bits_ff > WBITS_W'(MAX_WORD_BITS)) ? WBITS_W'(MAX_WORD_BITS)
                 : word_offset_bits_ff;
      offset   = wbits + WBITS_W'(BYTE_BITS);
      set_mask = MAX_SET_BITS'((7'd1 << sbits) - 7'd1);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fire      = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);

   assign req_block = req_address >> offset;
   assign set_in    = req_block[MAX_SET_BITS-1:0] & set_mask;
   assign cur_block = addr_ff >> offset;
   assign cur_tag   = TAG_BITS'(cur_block >> sbits);

   // A set never written since reset has no valid ways and a zero pointer.
   always_comb begin
      cur_row = rd_row_ff;
      if (!row_valid_ff[set_ff]) begin
         cur_row.valid  = '0;
         cur_row.victim = '0;
      end
   end

   sacl_way_select u_way_select (
      .row_in     (cur_row),
      .tag_in     (cur_tag),
      .ways_in    (ways),
      .result_out (lookup)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         rsp_valid_ff        <= 1'b0;
         row_valid_ff        <= '0;
         hit_total_ff        <= '0;
         miss_total_ff       <= '0;
         set_index_bits_ff   <= '0;
         ways_in_use_ff      <= WAY_CNT_BITS'(1);
         word_offset_bits_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            row_valid_ff[set_ff] <= 1'b1;
            if (lookup.hit) begin
               if (hit_total_ff != '1) begin
                  hit_total_ff <= hit_total_ff + COUNT_BITS'(1);
               end
            end else begin
               if (miss_total_ff != '1) begin
                  miss_total_ff <= miss_total_ff + COUNT_BITS'(1);
               end
            end
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SET_INDEX_BITS:   set_index_bits_ff   <= csr_wdata[SBITS_W-1:0];
               CSR_WAYS_IN_USE:      ways_in_use_ff      <= csr_wdata[WAY_CNT_BITS-1:0];
               CSR_WORD_OFFSET_BITS: word_offset_bits_ff <= csr_wdata[WBITS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers and the row memory.
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= req_address;
         set_ff    <= set_in;
         rd_row_ff <= tag_mem[set_in];
      end
      if (fire) begin
         tag_mem[set_ff] <= lookup.row;
         rsp_hit_ff      <= lookup.hit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_hit_total  = hit_total_ff;
   assign rsp_miss_total = miss_total_ff;

endmodule

// ----- verif/tb_set_assoc_cache_tag_lookup_unit.sv -----
// Self-checking testbench for set_assoc_cache_tag_lookup_unit: directed and random address
// streams under changing cache geometries, checked against a scoreboard with its own predictor.
// Depends on sacl_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lookup_unit;
   import sacl_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_PHASES = 14;
   localparam int WORDS_PER_PHASE = 100;
   localparam int PRESET_PHASES = 6;
   localparam int PRESET_SETS [PRESET_PHASES] = '{0, 6, 7, 1, 6, 3};
   localparam int PRESET_WAYS [PRESET_PHASES] = '{0, 8, 9, 3, 1, 4};
   localparam int PRESET_WORDS[PRESET_PHASES] = '{0, 8, 9, 15, 0, 2};

   typedef struct {
      bit                  hit;
      bit [COUNT_BITS-1:0] hit_total;
      bit [COUNT_BITS-1:0] miss_total;
   } lookup_result_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   class tag_lookup_scoreboard;
      bit [SBITS_W-1:0]       set_bits_reg;
      bit [CSR_DATA_BITS-1:0] ways_reg;
      bit [WBITS_W-1:0]       word_bits_reg;
      bit                     entry_valid[NUM_SETS][MAX_WAYS];
      bit [TAG_BITS-1:0]      entry_tag[NUM_SETS][MAX_WAYS];
      bit [WAY_IDX_BITS-1:0]  next_victim[NUM_SETS];
      bit [COUNT_BITS-1:0]    hits;
      bit [COUNT_BITS-1:0]    misses;
      lookup_result_type      pending_results[$];
      int                     errors;

      function new();
         set_bits_reg = '0;
         ways_reg = 1;
         word_bits_reg = '0;
         hits = '0;
         misses = '0;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_SET_INDEX_BITS:   set_bits_reg = data[SBITS_W-1:0];
            CSR_WAYS_IN_USE:      ways_reg = data;
            CSR_WORD_OFFSET_BITS: word_bits_reg = data;
            default: ;
         endcase
      endfunction

      function int unsigned eff_set_bits();
         return (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
      endfunction

      function int unsigned eff_ways();
         if (ways_reg == 0) return 1;
         return (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
      endfunction

      function int unsigned eff_offset();
         return ((word_bits_reg > MAX_WORD_BITS) ? MAX_WORD_BITS : word_bits_reg) + BYTE_BITS;
      endfunction

      // Searches the set as the unit does and queues the response word this address causes.
      function void note_access(logic [ADDR_BITS-1:0] addr);
         int unsigned sbits, ways, set_no, w, v;
         bit [ADDR_BITS-1:0] block;
         bit [TAG_BITS-1:0] tag;
         bit hit, decided;
         lookup_result_type r;
         sbits = eff_set_bits();
         ways = eff_ways();
         block = addr >> eff_offset();
         set_no = block & ((32'd1 << sbits) - 1);
         tag = TAG_BITS'(block >> sbits);
         hit = 1'b0;
         decided = 1'b0;
         for (w = 0; w < ways && !decided; w++) begin
            if (!entry_valid[set_no][w]) begin
               entry_valid[set_no][w] = 1'b1;
               entry_tag[set_no][w] = tag;
               decided = 1'b1;
            end else if (entry_tag[set_no][w] == tag) begin
               hit = 1'b1;
               decided = 1'b1;
            end
         end
         if (!decided) begin
            // A pointer left beyond a lowered way count restarts at way 0.
            v = next_victim[set_no];
            if (v >= ways) v = 0;
            entry_valid[set_no][v] = 1'b1;
            entry_tag[set_no][v] = tag;
            next_victim[set_no] = WAY_IDX_BITS'((v + 1) % ways);
         end
         if (hit) begin
            if (hits != '1) hits++;
         end else begin
            if (misses != '1) misses++;
         end
         r.hit = hit;
         r.hit_total = hits;
         r.miss_total = misses;
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic hit, logic [COUNT_BITS-1:0] hit_total,
                          logic [COUNT_BITS-1:0] miss_total);
         lookup_result_type r;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response word with nothing expected, hit %0b", hit));
            return;
         end
         r = pending_results.pop_front();
         if (hit !== r.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", hit, r.hit));
         if (hit_total !== r.hit_total)
            report_mismatch($sformatf("hit_total %0d, expected %0d", hit_total, r.hit_total));
         if (miss_total !== r.miss_total)
            report_mismatch($sformatf("miss_total %0d, expected %0d", miss_total, r.miss_total));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [ADDR_BITS-1:0]      req_address;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_hit;
   logic [COUNT_BITS-1:0]     rsp_hit_total;
   logic [COUNT_BITS-1:0]     rsp_miss_total;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tag_lookup_scoreboard sb;
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned stall_mode_left = 0;
   int unsigned stall_tick = 0;

   set_assoc_cache_tag_lookup_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_miss_total   (rsp_miss_total),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: checks each accepted response word and stalls in modes of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_hit, rsp_hit_total, rsp_miss_total);
         if (stall_mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(16, 160);
         end else begin
            stall_mode_left--;
         end
         stall_tick++;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_tick % 7 < 3);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [ADDR_BITS-1:0] compose_address(int unsigned sbits, int unsigned off,
                                                            logic [31:0] tag_val,
                                                            int unsigned set_no,
                                                            logic [31:0] low);
      logic [ADDR_BITS-1:0] set_field;
      set_field = (ADDR_BITS'(set_no) & ((32'd1 << sbits) - 1)) << off;
      return (tag_val << (sbits + off)) | set_field | (low & ((32'd1 << off) - 1));
   endfunction

   // Sends one address word; the sender runs in bursts with random gaps between them.
   task automatic issue_access(logic [ADDR_BITS-1:0] addr);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         if ($urandom_range(0, 4) == 0)
            burst_left = $urandom_range(50, 120);
         else
            burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (req_stall);
      sb.note_access(addr);
      burst_left--;
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   // The unused index is poked too; it must leave the geometry alone.
   task automatic program_geometry(logic [CSR_DATA_BITS-1:0] set_bits,
                                   logic [CSR_DATA_BITS-1:0] ways,
                                   logic [CSR_DATA_BITS-1:0] word_bits);
      wait_until_idle();
      csr_write(CSR_SET_INDEX_BITS, set_bits);
      csr_write(CSR_WAYS_IN_USE, ways);
      csr_write(CSR_WORD_OFFSET_BITS, word_bits);
      csr_write(CSR_UNUSED_INDEX, CSR_DATA_BITS'($urandom()));
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned sbits, ways, off, pool_size, set_no, t;
      logic [31:0] tag_pool[12];
      int unsigned hot_sets[4];
      logic [ADDR_BITS-1:0] addr;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_address <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: one set, one way, four-byte blocks.
      issue_access(32'h0000_0000);
      issue_access(32'h0000_0003);
      issue_access(32'hFFFF_FFFF);
      issue_access(32'hFFFF_FFFC);

      // Four sets of two ways: fill, hit, then replace in set 1.
      program_geometry(2, 2, 1);
      issue_access(compose_address(2, 3, 1, 1, 0));
      issue_access(compose_address(2, 3, 2, 1, 7));
      issue_access(compose_address(2, 3, 1, 1, 5));
      issue_access(compose_address(2, 3, 2, 1, 0));
      issue_access(compose_address(2, 3, 32'h07FF_FFFF, 1, 0));
      // Dropping to one way leaves set 1's victim pointer out of range.
      program_geometry(2, 1, 1);
      issue_access(compose_address(2, 3, 4, 1, 0));
      // The entry kept in way 1 must hit again once the way is back in use.
      program_geometry(2, 2, 1);
      issue_access(compose_address(2, 3, 2, 1, 0));

      // Out-of-range register values clamp to 64 sets, 8 ways and 256-word blocks.
      program_geometry(7, 15, 15);
      for (t = 0; t < 9; t++)
         issue_access(compose_address(6, 10, (t == 8) ? 32'h0000_FFFF : t, 63, '1));
      issue_access(compose_address(6, 10, 1, 63, 0));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < PRESET_PHASES)
            program_geometry(CSR_DATA_BITS'(PRESET_SETS[p]), CSR_DATA_BITS'(PRESET_WAYS[p]),
                             CSR_DATA_BITS'(PRESET_WORDS[p]));
         else
            program_geometry(CSR_DATA_BITS'($urandom_range(0, 15)),
                             CSR_DATA_BITS'($urandom_range(0, 15)),
                             CSR_DATA_BITS'($urandom_range(0, 15)));
         sbits = sb.eff_set_bits();
         ways = sb.eff_ways();
         off = sb.eff_offset();
         // A few more tags than ways keeps a mix of hits, fills and replacements.
         pool_size = ways + $urandom_range(0, 3);
         foreach (tag_pool[i]) tag_pool[i] = $urandom();
         tag_pool[0] = '0;
         tag_pool[1] = '1;
         hot_sets[0] = 0;
         hot_sets[1] = (1 << sbits) - 1;
         hot_sets[2] = $urandom_range(0, (1 << sbits) - 1);
         hot_sets[3] = $urandom_range(0, (1 << sbits) - 1);
         repeat (WORDS_PER_PHASE) begin
            if ($urandom_range(0, 199) == 0) wait_until_idle();
            if ($urandom_range(0, 6) == 0) begin
               addr = $urandom();
            end else begin
               if ($urandom_range(0, 3) != 0)
                  set_no = hot_sets[$urandom_range(0, 3)];
               else
                  set_no = $urandom_range(0, (1 << sbits) - 1);
               addr = compose_address(sbits, off, tag_pool[$urandom_range(0, pool_size - 1)],
                                      set_no, $urandom());
            end
            issue_access(addr);
         end
      end

      wait_until_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
